@@ rtl/bpeg_pkg.sv @@
// Shared constants, codes and controller/datapath command and status types of the breakpoint envelope generator.
`default_nettype none
package bpeg_pkg;

    // Table size and derived index widths
    localparam int MAX_POINTS = 16;
    localparam int PT_IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths
    localparam int FUNC_W   = 3;
    localparam int X_W      = 9;
    localparam int Y_W      = 7;
    localparam int LEVEL_W  = 16;
    localparam int PHASE_W  = 2;
    localparam int INC_W    = 16;
    localparam int POS_W    = 26;
    localparam int FRAC_W   = 16;
    localparam int PIX_W    = POS_W - FRAC_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Interpolation datapath widths
    localparam int PROD_W   = Y_W + PIX_W + 1;
    localparam int DEN_W    = 16;
    localparam int QUO_W    = 17;
    localparam int REM_W    = 33;
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'h8000;
    localparam logic [DEN_W-1:0]   Y_SCALE   = 16'd100;
    localparam logic [X_W-1:0]     X_END     = 9'd500;

    // Register reset values
    localparam logic [INC_W-1:0] INC_RST = 16'd68;
    localparam logic [X_W-1:0]   SUS_RST = 9'd150;
    localparam logic [X_W-1:0]   REL_RST = 9'd500;

    // Envelope phases
    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_RUN  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SUS  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_REL  = 2'd3;

    // Item functions
    localparam logic [FUNC_W-1:0] FN_TICK = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ON   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_OFF  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ADD  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEL  = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REL = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic scan;
        logic mul;
        logic div;
        logic div_last;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic need_interp;
        logic scan_hit;
        logic scan_end;
    } sts_t;

endpackage
`default_nettype wire

@@ rtl/breakpoint_envelope_generator_unit.sv @@
// Breakpoint envelope generator top level: controller plus datapath.
//
// Usage: items enter on the s_ channel (valid/ready). func selects tick, note
// on, note off, add breakpoint or delete breakpoint. Only a tick makes a
// result item on the m_ channel: the Q1.15 level and the phase after the tick.
// Other items change the table or the phase only. A tick that needs
// interpolation scans the table one breakpoint per cycle, blends in the MUL
// state and runs a 17-step restoring divider; a tick without interpolation
// goes straight to the result hand-off. One item is in work at a time. The
// result sits in an output register: a new item is accepted while a result
// waits, but a finished tick holds in the controller until the receiver
// takes the previous result. Configuration is written through cfg_we/
// cfg_index/cfg_data; the user must write it only while the block is idle,
// which the block does not enforce. Synchronous reset (aresetn low) restores
// the two-point table, idle phase, position 0 and the register defaults.
`default_nettype none
module breakpoint_envelope_generator_unit (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire [bpeg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [bpeg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire [bpeg_pkg::FUNC_W-1:0]       s_func,
    input  wire [bpeg_pkg::X_W-1:0]          s_point_x,
    input  wire [bpeg_pkg::Y_W-1:0]          s_point_y,
    input  wire [bpeg_pkg::PT_IDX_W-1:0]     s_point_index,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [bpeg_pkg::LEVEL_W-1:0]     m_level,
    output logic [bpeg_pkg::PHASE_W-1:0]     m_phase
);
    import bpeg_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bpeg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bpeg_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_func        (s_func),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_point_index (s_point_index),
        .m_level       (m_level),
        .m_phase       (m_phase)
    );

endmodule
`default_nettype wire

@@ rtl/bpeg_dp.sv @@
// Datapath: breakpoint table, phase and position, segment scan, divider, result register.
`default_nettype none
module bpeg_dp (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire bpeg_pkg::cmd_t              cmd,
    output bpeg_pkg::sts_t                   sts,
    input  wire                              cfg_we,
    input  wire [bpeg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [bpeg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire [bpeg_pkg::FUNC_W-1:0]       s_func,
    input  wire [bpeg_pkg::X_W-1:0]          s_point_x,
    input  wire [bpeg_pkg::Y_W-1:0]          s_point_y,
    input  wire [bpeg_pkg::PT_IDX_W-1:0]     s_point_index,
    output logic [bpeg_pkg::LEVEL_W-1:0]     m_level,
    output logic [bpeg_pkg::PHASE_W-1:0]     m_phase
);
    import bpeg_pkg::*;

    logic [INC_W-1:0]   inc_reg;
    logic [X_W-1:0]     sus_reg;
    logic [X_W-1:0]     rel_reg;
    logic [X_W-1:0]     bp_x_reg [MAX_POINTS];
    logic [Y_W-1:0]     bp_y_reg [MAX_POINTS];
    logic [X_W-1:0]     bp_x_next [MAX_POINTS];
    logic [Y_W-1:0]     bp_y_next [MAX_POINTS];
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [LEVEL_W-1:0] held_reg;
    logic [PIX_W-1:0]   xq_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [X_W-1:0]     x0_reg;
    logic [Y_W-1:0]     y0_reg;
    logic [X_W-1:0]     x1_reg;
    logic [Y_W-1:0]     y1_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [REM_W-1:0]   dsh_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [LEVEL_W-1:0] m_level_reg;
    logic [PHASE_W-1:0] m_phase_reg;

    logic [MAX_POINTS-1:0] gt;
    logic [MAX_POINTS-1:0] prev_gt;
    logic                  any_gt;
    logic [POS_W:0]        adv_sum;
    logic [POS_W-1:0]      adv;
    logic [PIX_W-1:0]      adv_pix;
    logic [PIX_W-1:0]      pos_pix;
    logic [X_W-1:0]        scan_x;
    logic [Y_W-1:0]        scan_y;
    logic                  del_ok;
    logic [CNT_W-1:0]      del_idx;
    logic [PIX_W-1:0]      d_hi;
    logic [PIX_W-1:0]      d_lo;
    logic [PROD_W-1:0]     mix;
    logic [DEN_W-1:0]      den;
    logic                  on_knot;
    logic [REM_W-1:0]      quo_rem;
    logic [QUO_W-1:0]      quo_step;
    logic                  rem_ge;

    // Saturating position advance
    assign adv_sum = {1'b0, pos_reg} + (POS_W+1)'(inc_reg);
    assign adv     = adv_sum[POS_W] ? {POS_W{1'b1}} : adv_sum[POS_W-1:0];
    assign adv_pix = adv[POS_W-1:FRAC_W];
    assign pos_pix = pos_reg[POS_W-1:FRAC_W];

    // Scan read of the current table entry
    assign scan_x = bp_x_reg[idx_reg[PT_IDX_W-1:0]];
    assign scan_y = bp_y_reg[idx_reg[PT_IDX_W-1:0]];

    // Status toward the controller
    always_comb begin
        sts.is_tick     = (s_func == FN_TICK);
        sts.need_interp = 1'b0;
        unique case (phase_reg)
            PH_RUN:  sts.need_interp = (adv_pix < PIX_W'(sus_reg));
            PH_SUS:  sts.need_interp = 1'b1;
            PH_REL:  sts.need_interp = (adv_pix < PIX_W'(rel_reg));
            default: sts.need_interp = 1'b0;
        endcase
        sts.scan_end = (idx_reg >= cnt_reg);
        sts.scan_hit = (xq_reg <= PIX_W'(scan_x));
    end

    // Insert and delete, computed over the whole table
    always_comb begin
        for (int k = 0; k < MAX_POINTS; k++) begin
            gt[k] = (CNT_W'(k) < cnt_reg) && (bp_x_reg[k] > s_point_x);
        end
        prev_gt[0] = 1'b0;
        for (int k = 1; k < MAX_POINTS; k++) begin
            prev_gt[k] = gt[k-1];
        end
        any_gt  = |gt;
        del_idx = CNT_W'(s_point_index);
        del_ok  = (del_idx != '0) && (del_idx < cnt_reg - CNT_W'(1));

        cnt_next = cnt_reg;
        for (int k = 0; k < MAX_POINTS; k++) begin
            bp_x_next[k] = bp_x_reg[k];
            bp_y_next[k] = bp_y_reg[k];
        end
        if (s_func == FN_ADD && cnt_reg < CNT_W'(MAX_POINTS) && any_gt) begin
            cnt_next = cnt_reg + CNT_W'(1);
            for (int k = 0; k < MAX_POINTS; k++) begin
                if (gt[k] && !prev_gt[k]) begin
                    bp_x_next[k] = s_point_x;
                    bp_y_next[k] = s_point_y;
                end else if (prev_gt[k]) begin
                    bp_x_next[k] = bp_x_reg[(k + MAX_POINTS - 1) % MAX_POINTS];
                    bp_y_next[k] = bp_y_reg[(k + MAX_POINTS - 1) % MAX_POINTS];
                end
            end
        end else if (s_func == FN_DEL && del_ok) begin
            cnt_next = cnt_reg - CNT_W'(1);
            for (int k = 0; k < MAX_POINTS; k++) begin
                if (CNT_W'(k) == cnt_reg - CNT_W'(1)) begin
                    bp_x_next[k] = '0;
                    bp_y_next[k] = '0;
                end else if (CNT_W'(k) >= del_idx && CNT_W'(k) < cnt_reg - CNT_W'(1)) begin
                    bp_x_next[k] = bp_x_reg[(k + 1) % MAX_POINTS];
                    bp_y_next[k] = bp_y_reg[(k + 1) % MAX_POINTS];
                end
            end
        end
    end

    // Segment blend and denominator
    always_comb begin
        on_knot = (xq_reg == PIX_W'(x1_reg));
        d_hi    = PIX_W'(x1_reg) - xq_reg;
        d_lo    = xq_reg - PIX_W'(x0_reg);
        if (on_knot) begin
            mix = PROD_W'(y1_reg);
            den = Y_SCALE;
        end else begin
            mix = PROD_W'(y0_reg * d_hi) + PROD_W'(y1_reg * d_lo);
            den = DEN_W'(Y_SCALE * DEN_W'(x1_reg - x0_reg));
        end
    end

    // One restoring division step
    always_comb begin
        rem_ge   = (rem_reg >= dsh_reg);
        quo_rem  = rem_ge ? rem_reg - dsh_reg : rem_reg;
        quo_step = {quo_reg[QUO_W-2:0], rem_ge};
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc_reg <= INC_RST;
            sus_reg <= SUS_RST;
            rel_reg <= REL_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_INC: inc_reg <= cfg_data[INC_W-1:0];
                CFG_SUS: sus_reg <= cfg_data[X_W-1:0];
                CFG_REL: rel_reg <= cfg_data[X_W-1:0];
                default: ;
            endcase
        end
    end

    // Table, phase, position and level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_POINTS; k++) begin
                bp_x_reg[k] <= (k == 1) ? X_END : '0;
                bp_y_reg[k] <= '0;
            end
            cnt_reg   <= CNT_W'(2);
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            held_reg  <= '0;
        end else begin
            if (cmd.accept) begin
                bp_x_reg <= bp_x_next;
                bp_y_reg <= bp_y_next;
                cnt_reg  <= cnt_next;
                unique case (s_func)
                    FN_TICK: begin
                        unique case (phase_reg)
                            PH_RUN: begin
                                pos_reg <= adv;
                                if (adv_pix >= PIX_W'(sus_reg)) begin
                                    phase_reg <= PH_SUS;
                                end
                            end
                            PH_REL: begin
                                if (adv_pix >= PIX_W'(rel_reg)) begin
                                    phase_reg <= PH_IDLE;
                                    pos_reg   <= '0;
                                    held_reg  <= '0;
                                end else begin
                                    pos_reg <= adv;
                                end
                            end
                            default: ;
                        endcase
                    end
                    FN_ON: begin
                        phase_reg <= (pos_pix < PIX_W'(sus_reg)) ? PH_RUN : PH_SUS;
                    end
                    FN_OFF: begin
                        if (phase_reg != PH_IDLE) begin
                            phase_reg <= PH_REL;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.scan && sts.scan_end) begin
                held_reg <= '0;
            end
            if (cmd.div_last) begin
                held_reg <= (quo_step > QUO_W'(LEVEL_ONE)) ? LEVEL_ONE : quo_step[LEVEL_W-1:0];
            end
        end
    end

    // Scan, multiply and divide registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            xq_reg  <= (phase_reg == PH_SUS) ? PIX_W'(sus_reg) : adv_pix;
            idx_reg <= CNT_W'(1);
            x0_reg  <= bp_x_reg[0];
            y0_reg  <= bp_y_reg[0];
        end
        if (cmd.scan) begin
            x1_reg <= scan_x;
            y1_reg <= scan_y;
            if (!sts.scan_hit) begin
                x0_reg  <= scan_x;
                y0_reg  <= scan_y;
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
        if (cmd.mul) begin
            rem_reg <= (REM_W'(mix) << (LEVEL_W - 1)) + REM_W'(den >> 1);
            dsh_reg <= REM_W'(den) << (QUO_W - 1);
            quo_reg <= '0;
        end
        if (cmd.div) begin
            rem_reg <= quo_rem;
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= quo_step;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_level_reg <= held_reg;
            m_phase_reg <= phase_reg;
        end
    end

    assign m_level = m_level_reg;
    assign m_phase = m_phase_reg;

endmodule
`default_nettype wire

@@ rtl/bpeg_ctrl.sv @@
// Controller: sequences accept, segment scan, blend, division and result hand-off.
`default_nettype none
module bpeg_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire                 m_ready,
    input  wire bpeg_pkg::sts_t sts,
    output bpeg_pkg::cmd_t      cmd
);
    import bpeg_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic                 out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (sts.is_tick) begin
                        state_next = sts.need_interp ? ST_SCAN : ST_OUT;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_end) begin
                    state_next = ST_OUT;
                end else if (sts.scan_hit) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul      = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div      = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    cmd.div_last = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = cmd.out_load ? 1'b1 : (m_valid_reg && !m_ready);
    end

    // Hold state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

@@ rtl/bpeg_checker.sv @@
// Port checker for the breakpoint envelope generator and its bind.
`default_nettype none
module bpeg_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              s_valid,
    input wire                              s_ready,
    input wire [bpeg_pkg::FUNC_W-1:0]       s_func,
    input wire                              m_valid,
    input wire                              m_ready,
    input wire [bpeg_pkg::LEVEL_W-1:0]      m_level,
    input wire [bpeg_pkg::PHASE_W-1:0]      m_phase
);
    import bpeg_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level) && $stable(m_phase))
        else $error("result changed while stalled");

    // Level never exceeds one
    a_level_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_level <= LEVEL_ONE)
        else $error("level above 1.0");

    // Idle phase reports silence
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_phase == PH_IDLE |-> m_level == '0)
        else $error("nonzero level while idle");

    // A tick keeps the block busy for the next cycle
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FN_TICK |=> !s_ready)
        else $error("ready right after a tick item");

endmodule

bind breakpoint_envelope_generator_unit bpeg_checker u_bpeg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_func  (s_func),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_level (m_level),
    .m_phase (m_phase)
);
`default_nettype wire
